[hdl/tpwq_pkg.sv]
// Package with the types, codes and constants of the targeted priority work queue.
`timescale 1ns / 1ps
package tpwq_pkg;

  localparam int unsigned DefaultSlots = 64;
  localparam int unsigned Types = 16;
  localparam int unsigned Workers = 64;
  localparam logic [30:0] SoftPenaltyReset = 31'd65536;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_RET   = 2'd2,
    ST_NONE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_GET  = 2'd1,
    OP_FULL = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE  = 2'd1,
    BK_SCAN  = 2'd2,
    BK_DONE  = 2'd3
  } back_state_e;

  typedef struct packed {
    op_e         op;
    logic [3:0]  unit_kind;
    logic [5:0]  worker;
    logic        worker_ok;
    logic        targeted;
    logic        soft_tgt;
    logic [31:0] priority_val;
    logic [31:0] handle;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  unit_kind;
    logic [5:0]  target;
    logic        targeted;
    logic        soft_tgt;
    logic [31:0] priority_val;
    logic [31:0] handle;
  } slot_t;

endpackage

[hdl/tpwq_front.sv]
// Front end: checks and classifies requests and holds them in a two-entry queue.
`timescale 1ns / 1ps
module tpwq_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                req_type_i,
  input  logic [3:0]          work_type_i,
  input  logic [5:0]          target_worker_i,
  input  logic                has_target_i,
  input  logic                soft_flag_i,
  input  logic signed [31:0]  priority_req_i,
  input  logic [31:0]         handle_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                avail_o,
  output tpwq_pkg::cmd_t      cmd_o
);
  import tpwq_pkg::*;

  cmd_t       ent_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cls;
  logic       type_ok, worker_ok;

  always_comb begin
    type_ok = int'(work_type_i) < Types;
    worker_ok = int'(target_worker_i) < Workers;
    cls.unit_kind = work_type_i;
    cls.worker = target_worker_i;
    cls.worker_ok = worker_ok;
    cls.targeted = has_target_i;
    cls.soft_tgt = has_target_i & soft_flag_i;
    cls.priority_val = priority_req_i;
    cls.handle = handle_i;
    if (!req_type_i) begin
      cls.op = (!type_ok || (has_target_i && !worker_ok)) ? OP_FULL : OP_ADD;
    end else begin
      cls.op = type_ok ? OP_GET : OP_NONE;
    end
  end

  always_comb begin
    wp_d = push_i ? ~wp_q : wp_q;
    rp_d = pop_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= cls;
    end
  end

  assign full_o = cnt_q == 2'd2;
  assign avail_o = cnt_q != 2'd0;
  assign cmd_o = ent_q[rp_q];

endmodule

[hdl/tpwq_back.sv]
// Back end: slot store memories and the sequencer that scans them to add or take units.
`timescale 1ns / 1ps
module tpwq_back #(
  parameter int unsigned Slots = tpwq_pkg::DefaultSlots
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [30:0]         soft_penalty_i,
  input  logic                avail_i,
  input  tpwq_pkg::cmd_t      cmd_i,
  output logic                pop_o,
  output logic                clearing_o,
  output logic                done_o,
  output logic [1:0]          status_o,
  output logic [31:0]         out_handle_o,
  output logic signed [31:0]  out_priority_o,
  output logic                via_target_o
);
  import tpwq_pkg::*;

  localparam int unsigned IW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CW = $clog2(Slots + 1);

  slot_t slot_mem [Slots];
  logic  vld_mem [Slots];
  slot_t rd_q;
  logic  rv_q;

  back_state_e st_q, st_d;
  cmd_t        cmd_q, cmd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic        pend_q, pend_d;
  logic [IW-1:0] pa_q, pa_d;
  logic [IW-1:0] rd_addr;
  logic        issue;

  logic        ff_q, ff_d;
  logic [IW-1:0] fi_q, fi_d;
  logic        tf_q, tf_d, uf_q, uf_d;
  logic [IW-1:0] ti_q, ti_d, ui_q, ui_d;
  logic signed [31:0] tb_q, tb_d, ub_q, ub_d;
  logic [31:0] tp_q, tp_d, up_q, up_d, th_q, th_d, uh_q, uh_d;

  logic        done_q, done_d, via_q, via_d;
  logic [1:0]  stat_q, stat_d;
  logic [31:0] oh_q, oh_d, op_q, op_d;

  logic        mw_en, vw_en, vw_val;
  logic [IW-1:0] mw_addr;

  logic signed [32:0] diff;
  logic signed [31:0] rank;
  logic        tmatch, umatch;

  always_comb begin
    diff = {rd_q.priority_val[31], rd_q.priority_val} - $signed({2'b00, soft_penalty_i});
    if (diff[32:31] == 2'b10) begin
      rank = 32'sh8000_0000;
    end else begin
      rank = diff[31:0];
    end
    if (!rd_q.soft_tgt) begin
      rank = rd_q.priority_val;
    end
    tmatch = pend_q && rv_q && rd_q.unit_kind == cmd_q.unit_kind && rd_q.targeted &&
             rd_q.target == cmd_q.worker && cmd_q.worker_ok &&
             (!tf_q || $signed(rd_q.priority_val) > tb_q);
    umatch = pend_q && rv_q && rd_q.unit_kind == cmd_q.unit_kind &&
             (!rd_q.targeted || rd_q.soft_tgt) && (!uf_q || rank > ub_q);
  end

  always_comb begin
    st_d = st_q;
    issue = cnt_q < CW'(Slots);
    case (st_q)
      BK_CLEAR: if (!issue) st_d = BK_IDLE;
      BK_IDLE: begin
        if (avail_i) begin
          st_d = (cmd_i.op == OP_ADD || cmd_i.op == OP_GET) ? BK_SCAN : BK_DONE;
        end
      end
      BK_SCAN: if (!issue && !pend_q) st_d = BK_DONE;
      BK_DONE: st_d = BK_IDLE;
      default: st_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_d = cmd_q;
    cnt_d = cnt_q;
    pend_d = 1'b0;
    pa_d = pa_q;
    rd_addr = cnt_q[IW-1:0];
    pop_o = 1'b0;
    ff_d = ff_q; fi_d = fi_q;
    tf_d = tf_q; ti_d = ti_q; tb_d = tb_q; tp_d = tp_q; th_d = th_q;
    uf_d = uf_q; ui_d = ui_q; ub_d = ub_q; up_d = up_q; uh_d = uh_q;
    done_d = 1'b0; stat_d = stat_q; oh_d = oh_q; op_d = op_q; via_d = via_q;
    mw_en = 1'b0; vw_en = 1'b0; vw_val = 1'b0; mw_addr = cnt_q[IW-1:0];
    case (st_q)
      BK_CLEAR: begin
        if (issue) begin
          vw_en = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      BK_IDLE: begin
        if (avail_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          cnt_d = '0;
          ff_d = 1'b0; tf_d = 1'b0; uf_d = 1'b0;
        end
      end
      BK_SCAN: begin
        if (issue) begin
          pend_d = 1'b1;
          pa_d = cnt_q[IW-1:0];
          cnt_d = cnt_q + 1'b1;
        end
        if (pend_q && !rv_q && !ff_q) begin
          ff_d = 1'b1;
          fi_d = pa_q;
        end
        if (tmatch) begin
          tf_d = 1'b1; ti_d = pa_q; tb_d = rd_q.priority_val;
          tp_d = rd_q.priority_val; th_d = rd_q.handle;
        end
        if (umatch) begin
          uf_d = 1'b1; ui_d = pa_q; ub_d = rank;
          up_d = rd_q.priority_val; uh_d = rd_q.handle;
        end
      end
      BK_DONE: begin
        done_d = 1'b1;
        oh_d = '0; op_d = '0; via_d = 1'b0;
        case (cmd_q.op)
          OP_ADD: begin
            if (ff_q) begin
              stat_d = ST_ADDED;
              mw_en = 1'b1; vw_en = 1'b1; vw_val = 1'b1; mw_addr = fi_q;
            end else begin
              stat_d = ST_FULL;
            end
          end
          OP_GET: begin
            if (tf_q) begin
              stat_d = ST_RET; oh_d = th_q; op_d = tp_q; via_d = 1'b1;
              vw_en = 1'b1; mw_addr = ti_q;
            end else if (uf_q) begin
              stat_d = ST_RET; oh_d = uh_q; op_d = up_q;
              vw_en = 1'b1; mw_addr = ui_q;
            end else begin
              stat_d = ST_NONE;
            end
          end
          OP_FULL: stat_d = ST_FULL;
          default: stat_d = ST_NONE;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_CLEAR;
      cnt_q <= '0;
      pend_q <= 1'b0;
      done_q <= 1'b0;
      ff_q <= 1'b0;
      tf_q <= 1'b0;
      uf_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      pend_q <= pend_d;
      done_q <= done_d;
      ff_q <= ff_d;
      tf_q <= tf_d;
      uf_q <= uf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; pa_q <= pa_d; fi_q <= fi_d;
    ti_q <= ti_d; tb_q <= tb_d; tp_q <= tp_d; th_q <= th_d;
    ui_q <= ui_d; ub_q <= ub_d; up_q <= up_d; uh_q <= uh_d;
    stat_q <= stat_d; oh_q <= oh_d; op_q <= op_d; via_q <= via_d;
  end

  always_ff @(posedge clk_i) begin
    if (mw_en) begin
      slot_mem[mw_addr] <= '{unit_kind: cmd_q.unit_kind,
                             target: cmd_q.targeted ? cmd_q.worker : 6'd0,
                             targeted: cmd_q.targeted, soft_tgt: cmd_q.soft_tgt,
                             priority_val: cmd_q.priority_val, handle: cmd_q.handle};
    end
    rd_q <= slot_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (vw_en) begin
      vld_mem[mw_addr] <= vw_val;
    end
    rv_q <= vld_mem[rd_addr];
  end

  assign clearing_o = st_q == BK_CLEAR;
  assign done_o = done_q;
  assign status_o = stat_q;
  assign out_handle_o = oh_q;
  assign out_priority_o = op_q;
  assign via_target_o = via_q;

endmodule

[hdl/targeted_priority_work_queue.sv]
// Top level of the targeted priority work queue: config register, front end and back end.
//
//   Channel   Direction  Handshake               Payload
//   request   in         start & !busy           req_type_i .. handle_i
//   result    out        done_o, one cycle       status_o .. via_target_o
//   config    in         cfg_we_i                cfg_wdata_i (soft penalty)
//
// A request that passes the range checks is handled in the back end by a scan that
// reads the slot memory one entry per cycle; a refused request skips the scan. After
// reset a clearing pass marks every slot free; busy is high meanwhile. The two-entry
// request queue lets a new beat in while the back end works.
// The receiver cannot stall; each result beat lasts one cycle.
`timescale 1ns / 1ps
module targeted_priority_work_queue #(
  parameter int unsigned Slots = tpwq_pkg::DefaultSlots
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               req_type_i,
  input  logic [3:0]         work_type_i,
  input  logic [5:0]         target_worker_i,
  input  logic               has_target_i,
  input  logic               soft_flag_i,
  input  logic signed [31:0] priority_req_i,
  input  logic [31:0]        handle_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [31:0]        out_handle_o,
  output logic signed [31:0] out_priority_o,
  output logic               via_target_o,
  input  logic               cfg_we_i,
  input  logic [30:0]        cfg_wdata_i
);
  import tpwq_pkg::*;

  logic [30:0] pen_q;
  logic        full, avail, pop, clearing;
  cmd_t        cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q <= SoftPenaltyReset;
    end else if (cfg_we_i) begin
      pen_q <= cfg_wdata_i;
    end
  end

  assign busy = full | clearing;

  tpwq_front u_front (
    .clk_i, .rst_ni,
    .push_i(start & ~busy),
    .req_type_i, .work_type_i, .target_worker_i, .has_target_i, .soft_flag_i,
    .priority_req_i, .handle_i,
    .pop_i(pop), .full_o(full), .avail_o(avail), .cmd_o(cmd)
  );

  tpwq_back #(.Slots(Slots)) u_back (
    .clk_i, .rst_ni,
    .soft_penalty_i(pen_q), .avail_i(avail), .cmd_i(cmd),
    .pop_o(pop), .clearing_o(clearing),
    .done_o, .status_o, .out_handle_o, .out_priority_o, .via_target_o
  );

endmodule

[hdl/tpwq_checker.sv]
// Port-level checker for the targeted priority work queue, bound to the top level.
`timescale 1ns / 1ps
module tpwq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [31:0] out_handle_o,
  input logic [31:0] out_priority_o,
  input logic        via_target_o
);
  import tpwq_pkg::*;

  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result beats in consecutive cycles");

  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_RET) |-> (out_handle_o == '0 && out_priority_o == '0))
    else $error("payload not zero on a beat without a unit");

  a_via_ret: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && via_target_o) |-> status_o == ST_RET)
    else $error("via_target set without a returned unit");

endmodule

bind targeted_priority_work_queue tpwq_checker u_checker (
  .clk_i, .rst_ni, .done_o, .status_o, .out_handle_o, .out_priority_o, .via_target_o
);
